### hdl/olist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olist_pkg
// Shared types and constants for the ordered list engine.
// ----------------------------------------------------------------------------
package olist_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_SEARCH    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_VALUE = 3'd4,
    CMD_DUMP      = 3'd5
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } stat_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MATCH,
    BK_APPLY,
    BK_DUMP
  } back_state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    stat_e                    status;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         pos;
    logic                     last;
  } res_t;

endpackage
`default_nettype wire

### hdl/olist_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olist_front
// Takes requests, decodes the command and forwards legal ones to the queue.
// Unused command codes are taken and dropped here.
// ----------------------------------------------------------------------------
module olist_front (
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic [olist_pkg::CMD_W-1:0]      command_i,
  input  wire logic signed [olist_pkg::DATA_W-1:0] value_i,
  output logic                                  push_o,
  output olist_pkg::req_t                       push_req_o,
  input  wire logic                             push_ready_i
);

  logic cmd_legal;

  always_comb begin
    case (command_i)
      olist_pkg::CMD_INS_FRONT,
      olist_pkg::CMD_INS_BACK,
      olist_pkg::CMD_SEARCH,
      olist_pkg::CMD_DEL_FRONT,
      olist_pkg::CMD_DEL_VALUE,
      olist_pkg::CMD_DUMP: cmd_legal = 1'b1;
      default:             cmd_legal = 1'b0;
    endcase
  end

  assign in_ready_o       = push_ready_i;
  assign push_o           = in_valid_i && push_ready_i && cmd_legal;
  assign push_req_o.cmd   = olist_pkg::cmd_e'(command_i);
  assign push_req_o.value = value_i;

endmodule
`default_nettype wire

### hdl/olist_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olist_queue
// Two-entry request queue between the decode front and the list back end.
// ----------------------------------------------------------------------------
module olist_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire olist_pkg::req_t push_req_i,
  output logic                 push_ready_o,
  output logic                 pop_valid_o,
  output olist_pkg::req_t      pop_req_o,
  input  wire logic            pop_i
);

  olist_pkg::req_t mem_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      fill_q, fill_d;
  logic            do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_req_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule
`default_nettype wire

### hdl/olist_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olist_back
// List storage as a chain of shifting cells, the command sequencer and the
// result register.
// ----------------------------------------------------------------------------
module olist_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire olist_pkg::req_t q_req_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  output olist_pkg::res_t      out_res_o,
  input  wire logic            out_ready_i
);

  localparam int unsigned DEPTH = olist_pkg::DEPTH;
  localparam int unsigned IDX_W = olist_pkg::IDX_W;
  localparam int unsigned CNT_W = olist_pkg::CNT_W;
  localparam int unsigned POS_W = olist_pkg::POS_W;

  olist_pkg::back_state_e          state_q, state_d;
  olist_pkg::cmd_e                 cmd_q, cmd_d;
  logic signed [olist_pkg::DATA_W-1:0] val_q, val_d;
  logic signed [olist_pkg::DATA_W-1:0] ent_q [DEPTH];
  logic signed [olist_pkg::DATA_W-1:0] ent_d [DEPTH];
  logic [CNT_W-1:0]                count_q, count_d;
  logic [DEPTH-1:0]                match_q, match_d;
  logic [IDX_W-1:0]                idx_q, idx_d;

  logic                            out_valid_q;
  olist_pkg::res_t                 out_q;
  olist_pkg::res_t                 res;
  logic                            load;
  logic                            out_free;

  logic                            found;
  logic [IDX_W-1:0]                first_idx;
  logic [DEPTH-1:0]                at_or_after;
  logic [DEPTH-1:0]                rm_mask;
  logic                            is_full;
  logic                            is_empty;
  logic                            dump_last;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_full  = (count_q >= CNT_W'(DEPTH));
  assign is_empty = (count_q == '0);
  assign found    = |match_q;
  assign dump_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  // first match and prefix-OR of the match vector
  always_comb begin
    first_idx      = '0;
    at_or_after[0] = match_q[0];
    for (int i = 1; i < DEPTH; i++) begin
      at_or_after[i] = at_or_after[i-1] | match_q[i];
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        first_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    val_d    = val_q;
    count_d  = count_q;
    match_d  = match_q;
    idx_d    = idx_q;
    q_pop_o  = 1'b0;
    load     = 1'b0;
    rm_mask  = '0;
    res      = '0;
    res.last = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      ent_d[i] = ent_q[i];
    end

    case (state_q)
      olist_pkg::BK_IDLE: begin
        q_pop_o = 1'b1;
        if (q_valid_i) begin
          cmd_d   = q_req_i.cmd;
          val_d   = q_req_i.value;
          state_d = olist_pkg::BK_MATCH;
        end
      end

      olist_pkg::BK_MATCH: begin
        for (int i = 0; i < DEPTH; i++) begin
          match_d[i] = (ent_q[i] == val_q) && (CNT_W'(i) < count_q);
        end
        state_d = olist_pkg::BK_APPLY;
      end

      olist_pkg::BK_APPLY: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = olist_pkg::BK_IDLE;
          case (cmd_q)
            olist_pkg::CMD_INS_FRONT: begin
              if (is_full) begin
                res.status = olist_pkg::ST_FULL;
              end else begin
                ent_d[0] = val_q;
                for (int i = 1; i < DEPTH; i++) begin
                  ent_d[i] = ent_q[i-1];
                end
                count_d = count_q + CNT_W'(1);
              end
            end
            olist_pkg::CMD_INS_BACK: begin
              if (is_full) begin
                res.status = olist_pkg::ST_FULL;
              end else begin
                ent_d[count_q[IDX_W-1:0]] = val_q;
                count_d = count_q + CNT_W'(1);
              end
            end
            olist_pkg::CMD_SEARCH: begin
              if (is_empty) begin
                res.status = olist_pkg::ST_EMPTY;
              end else if (!found) begin
                res.status = olist_pkg::ST_NOT_FOUND;
              end else begin
                res.pos = POS_W'(first_idx);
              end
            end
            olist_pkg::CMD_DEL_FRONT: begin
              if (is_empty) begin
                res.status = olist_pkg::ST_EMPTY;
              end else begin
                res.value = ent_q[0];
                rm_mask   = '1;
                count_d   = count_q - CNT_W'(1);
              end
            end
            olist_pkg::CMD_DEL_VALUE: begin
              if (is_empty) begin
                res.status = olist_pkg::ST_EMPTY;
              end else if (!found) begin
                res.status = olist_pkg::ST_NOT_FOUND;
              end else begin
                res.value = val_q;
                rm_mask   = at_or_after;
                count_d   = count_q - CNT_W'(1);
              end
            end
            olist_pkg::CMD_DUMP: begin
              if (is_empty) begin
                res.status = olist_pkg::ST_EMPTY;
              end else begin
                res.value = ent_q[0];
                if (count_q != CNT_W'(1)) begin
                  res.last = 1'b0;
                  idx_d    = IDX_W'(1);
                  state_d  = olist_pkg::BK_DUMP;
                end
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
          // close the gap left by a removed cell
          for (int i = 0; i < DEPTH - 1; i++) begin
            if (rm_mask[i]) begin
              ent_d[i] = ent_q[i+1];
            end
          end
        end
      end

      olist_pkg::BK_DUMP: begin
        if (out_free) begin
          load      = 1'b1;
          res.value = ent_q[idx_q];
          res.last  = dump_last;
          if (dump_last) begin
            state_d = olist_pkg::BK_IDLE;
          end else begin
            idx_d = idx_q + IDX_W'(1);
          end
        end
      end

      default: begin
        state_d = olist_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olist_pkg::BK_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    val_q   <= val_d;
    match_q <= match_d;
    idx_q   <= idx_d;
    for (int i = 0; i < DEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule
`default_nettype wire

### hdl/ordered_list_engine.sv
// Flow: a request taken at the input passes the queue, then the back end pops it,
// runs a parallel compare and applies it into the result register; a dump then
// gives one more entry per cycle while the output is free. The back end takes a
// new request only after the last is applied; a dump holds it until its last entry.
// Reset: rst_ni clears the list count, queue and output valid; cell contents
// are not cleared and are only read below the count.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered deque of signed values with search, delete and dump commands.
// ----------------------------------------------------------------------------
module ordered_list_engine (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [olist_pkg::CMD_W-1:0]         command_i,
  input  wire logic signed [olist_pkg::DATA_W-1:0] value_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [olist_pkg::STAT_W-1:0]             status_o,
  output logic signed [olist_pkg::DATA_W-1:0]      result_value_o,
  output logic [olist_pkg::POS_W-1:0]              position_o,
  output logic                                     last_o
);

  logic            push;
  logic            push_ready;
  olist_pkg::req_t push_req;
  logic            pop_valid;
  olist_pkg::req_t pop_req;
  logic            pop;
  olist_pkg::res_t res;

  olist_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .push_o       (push),
    .push_req_o   (push_req),
    .push_ready_i (push_ready)
  );

  olist_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_req_i   (push_req),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_req_o    (pop_req),
    .pop_i        (pop)
  );

  olist_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_req_i     (pop_req),
    .q_pop_o     (pop),
    .out_valid_o (out_valid_o),
    .out_res_o   (res),
    .out_ready_i (out_ready_i)
  );

  assign status_o       = res.status;
  assign result_value_o = res.value;
  assign position_o     = res.pos;
  assign last_o         = res.last;

endmodule
`default_nettype wire

### sim/ordered_list_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_test
// Self-checking bench for the ordered list engine. A short table of directed
// requests covers empty, not-found, duplicate, extreme and unused-code cases.
// Random segments then grow, shrink and mix the list, including bursts that
// fill it to capacity. Each accepted request updates a shadow list, which
// yields the expected responses. The monitor compares them in order against
// the accepted outputs. Both handshakes idle at random, and the receiver
// holds off once for a long stretch while the sender keeps pushing.
// ----------------------------------------------------------------------------
module ordered_list_engine_test;

  localparam logic [olist_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [olist_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  localparam logic signed [olist_pkg::DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [olist_pkg::DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  localparam int RANDOM_ITEMS = 260;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 24;

  typedef enum {BIAS_GROW, BIAS_SHRINK, BIAS_MIXED} bias_e;

  typedef struct {
    logic [olist_pkg::CMD_W-1:0]         cmd;
    logic signed [olist_pkg::DATA_W-1:0] val;
    bit                                  typed;
    olist_pkg::stat_e                    status;
    logic signed [olist_pkg::DATA_W-1:0] rvalue;
    logic [olist_pkg::POS_W-1:0]         pos;
  } step_row_t;

  localparam int DIR_ROWS = 21;

  logic                                clk_i          = 1'b0;
  logic                                rst_ni         = 1'b0;
  logic                                in_valid_i     = 1'b0;
  logic                                in_ready_o;
  logic [olist_pkg::CMD_W-1:0]         command_i      = '0;
  logic signed [olist_pkg::DATA_W-1:0] value_i        = '0;
  logic                                out_valid_o;
  logic                                out_ready_i    = 1'b0;
  logic [olist_pkg::STAT_W-1:0]        status_o;
  logic signed [olist_pkg::DATA_W-1:0] result_value_o;
  logic [olist_pkg::POS_W-1:0]         position_o;
  logic                                last_o;

  logic signed [olist_pkg::DATA_W-1:0] shadow_list[$];
  olist_pkg::res_t                     expected_results[$];
  int                                  mismatches       = 0;
  bit                                  sender_steady    = 1'b0;
  bit                                  hold_off_pending = 1'b0;

  // typed rows carry the single response known up front
  step_row_t directed_steps [DIR_ROWS] = '{
    '{olist_pkg::CMD_SEARCH,    32'sd5,    1'b1, olist_pkg::ST_EMPTY,     32'sd0,  6'd0},
    '{olist_pkg::CMD_DEL_FRONT, 32'sh5A5A, 1'b1, olist_pkg::ST_EMPTY,     32'sd0,  6'd0},
    '{olist_pkg::CMD_DEL_VALUE, 32'sd5,    1'b1, olist_pkg::ST_EMPTY,     32'sd0,  6'd0},
    '{olist_pkg::CMD_DUMP,      32'sd0,    1'b1, olist_pkg::ST_EMPTY,     32'sd0,  6'd0},
    '{olist_pkg::CMD_INS_FRONT, VAL_MIN,   1'b1, olist_pkg::ST_OK,        32'sd0,  6'd0},
    '{olist_pkg::CMD_INS_BACK,  VAL_MAX,   1'b1, olist_pkg::ST_OK,        32'sd0,  6'd0},
    '{olist_pkg::CMD_SEARCH,    VAL_MAX,   1'b1, olist_pkg::ST_OK,        32'sd0,  6'd1},
    '{olist_pkg::CMD_SEARCH,    32'sd0,    1'b1, olist_pkg::ST_NOT_FOUND, 32'sd0,  6'd0},
    '{olist_pkg::CMD_DEL_VALUE, 32'sd0,    1'b1, olist_pkg::ST_NOT_FOUND, 32'sd0,  6'd0},
    '{olist_pkg::CMD_INS_FRONT, VAL_MAX,   1'b1, olist_pkg::ST_OK,        32'sd0,  6'd0},
    '{olist_pkg::CMD_SEARCH,    VAL_MAX,   1'b1, olist_pkg::ST_OK,        32'sd0,  6'd0},
    '{olist_pkg::CMD_DUMP,      32'sd0,    1'b0, olist_pkg::ST_OK,        32'sd0,  6'd0},
    '{CMD_SPARE_LO,             VAL_MAX,   1'b0, olist_pkg::ST_OK,        32'sd0,  6'd0},
    '{CMD_SPARE_HI,             -32'sd1,   1'b0, olist_pkg::ST_OK,        32'sd0,  6'd0},
    '{olist_pkg::CMD_DEL_VALUE, VAL_MAX,   1'b1, olist_pkg::ST_OK,        VAL_MAX, 6'd0},
    '{olist_pkg::CMD_DEL_FRONT, 32'sd0,    1'b1, olist_pkg::ST_OK,        VAL_MIN, 6'd0},
    '{olist_pkg::CMD_INS_BACK,  -32'sd1,   1'b0, olist_pkg::ST_OK,        32'sd0,  6'd0},
    '{olist_pkg::CMD_DUMP,      32'sd0,    1'b0, olist_pkg::ST_OK,        32'sd0,  6'd0},
    '{olist_pkg::CMD_DEL_VALUE, -32'sd1,   1'b1, olist_pkg::ST_OK,        -32'sd1, 6'd0},
    '{olist_pkg::CMD_DEL_FRONT, VAL_MIN,   1'b1, olist_pkg::ST_OK,        VAL_MAX, 6'd0},
    '{olist_pkg::CMD_DUMP,      32'sd0,    1'b1, olist_pkg::ST_EMPTY,     32'sd0,  6'd0}
  };

  ordered_list_engine i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .position_o     (position_o),
    .last_o         (last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic olist_pkg::res_t make_res(olist_pkg::stat_e st,
                                               logic signed [olist_pkg::DATA_W-1:0] v,
                                               logic [olist_pkg::POS_W-1:0] p, logic l);
    olist_pkg::res_t r;
    r.status = st;
    r.value  = v;
    r.pos    = p;
    r.last   = l;
    return r;
  endfunction

  // Shadow list update plus expected responses for one accepted request.
  function automatic void predict_command(logic [olist_pkg::CMD_W-1:0] cmd,
                                          logic signed [olist_pkg::DATA_W-1:0] val);
    int hit;
    int n;
    hit = -1;
    n   = shadow_list.size();
    for (int i = 0; i < n; i++) begin
      if (shadow_list[i] == val && hit < 0) hit = i;
    end
    case (cmd)
      olist_pkg::CMD_INS_FRONT, olist_pkg::CMD_INS_BACK: begin
        if (n >= olist_pkg::DEPTH) begin
          expected_results.push_back(make_res(olist_pkg::ST_FULL, '0, '0, 1'b1));
        end else begin
          if (cmd == olist_pkg::CMD_INS_FRONT) shadow_list.push_front(val);
          else shadow_list.push_back(val);
          expected_results.push_back(make_res(olist_pkg::ST_OK, '0, '0, 1'b1));
        end
      end
      olist_pkg::CMD_SEARCH, olist_pkg::CMD_DEL_FRONT, olist_pkg::CMD_DEL_VALUE,
      olist_pkg::CMD_DUMP: begin
        if (n == 0) begin
          expected_results.push_back(make_res(olist_pkg::ST_EMPTY, '0, '0, 1'b1));
        end else if (cmd == olist_pkg::CMD_DEL_FRONT) begin
          expected_results.push_back(make_res(olist_pkg::ST_OK, shadow_list.pop_front(),
                                              '0, 1'b1));
        end else if (cmd == olist_pkg::CMD_DUMP) begin
          for (int i = 0; i < n; i++) begin
            expected_results.push_back(make_res(olist_pkg::ST_OK, shadow_list[i], '0,
                                                i == n - 1));
          end
        end else if (hit < 0) begin
          expected_results.push_back(make_res(olist_pkg::ST_NOT_FOUND, '0, '0, 1'b1));
        end else if (cmd == olist_pkg::CMD_SEARCH) begin
          expected_results.push_back(make_res(olist_pkg::ST_OK, '0,
                                              olist_pkg::POS_W'(hit), 1'b1));
        end else begin
          shadow_list.delete(hit);
          expected_results.push_back(make_res(olist_pkg::ST_OK, val, '0, 1'b1));
        end
      end
      default: ;  // unused codes: no state change, no response
    endcase
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // favor values already in the list so searches and deletes hit
  function automatic logic signed [olist_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4 && shadow_list.size() != 0)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    if (r < 6) return $signed($urandom_range(0, 6)) - 32'sd3;
    if (r == 6) begin
      case ($urandom_range(0, 3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $signed($urandom);
  endfunction

  function automatic logic [olist_pkg::CMD_W-1:0] pick_command(bias_e bias);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
    case (bias)
      BIAS_GROW: begin
        if (r < 70) return ($urandom_range(0, 1) != 0) ? olist_pkg::CMD_INS_FRONT
                                                       : olist_pkg::CMD_INS_BACK;
        if (r < 85) return olist_pkg::CMD_SEARCH;
        if (r < 92) return olist_pkg::CMD_DEL_VALUE;
        if (r < 96) return olist_pkg::CMD_DEL_FRONT;
        return olist_pkg::CMD_DUMP;
      end
      BIAS_SHRINK: begin
        if (r < 25) return ($urandom_range(0, 1) != 0) ? olist_pkg::CMD_INS_FRONT
                                                       : olist_pkg::CMD_INS_BACK;
        if (r < 45) return olist_pkg::CMD_DEL_FRONT;
        if (r < 75) return olist_pkg::CMD_DEL_VALUE;
        if (r < 90) return olist_pkg::CMD_SEARCH;
        return olist_pkg::CMD_DUMP;
      end
      default: return olist_pkg::CMD_W'($urandom_range(0, 5));
    endcase
  endfunction

  // Drive one request and hold it until taken, then record its responses.
  task automatic run_command(logic [olist_pkg::CMD_W-1:0] cmd,
                             logic signed [olist_pkg::DATA_W-1:0] val);
    int gap;
    gap = sender_steady ? 0 : idle_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    predict_command(cmd, val);
  endtask

  // Insert until full, overflow once or twice, then dump the whole list.
  task automatic fill_to_full(output int issued);
    issued = 0;
    while (shadow_list.size() < olist_pkg::DEPTH) begin
      run_command(($urandom_range(0, 1) != 0) ? olist_pkg::CMD_INS_FRONT
                                              : olist_pkg::CMD_INS_BACK, pick_value());
      issued++;
    end
    repeat ($urandom_range(1, 2)) begin
      run_command(($urandom_range(0, 1) != 0) ? olist_pkg::CMD_INS_FRONT
                                              : olist_pkg::CMD_INS_BACK, $signed($urandom));
      issued++;
    end
    run_command(olist_pkg::CMD_DUMP, $signed($urandom));
    issued++;
  endtask

  initial begin : stimulus
    int                          issued;
    int                          produced;
    int                          seg_len;
    bias_e                       bias;
    logic [olist_pkg::CMD_W-1:0] cmd;
    @(posedge rst_ni);
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      run_command(directed_steps[i].cmd, directed_steps[i].val);
      if (directed_steps[i].typed) begin
        expected_results[expected_results.size() - 1] = make_res(directed_steps[i].status,
            directed_steps[i].rvalue, directed_steps[i].pos, 1'b1);
      end
    end

    // receiver backs off while requests keep coming, so the input stalls
    sender_steady    = 1'b1;
    hold_off_pending = 1'b1;
    fill_to_full(issued);
    repeat (8) run_command(olist_pkg::CMD_SEARCH, pick_value());
    sender_steady = 1'b0;

    produced = 0;
    while (produced < RANDOM_ITEMS) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 15) begin
        fill_to_full(issued);
        produced += issued;
      end else begin
        bias    = bias_e'($urandom_range(0, 2));
        seg_len = $urandom_range(8, 30);
        repeat (seg_len) begin
          cmd = pick_command(bias);
          run_command(cmd, pick_value());
          if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI) produced++;
        end
      end
    end
    in_valid_i <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : receiver
    int stall_left;
    int span_left;
    bit steady;
    stall_left = 0;
    span_left  = 0;
    steady     = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (span_left == 0) begin
        steady    = ($urandom_range(0, 3) == 0);
        span_left = $urandom_range(40, 150);
      end
      span_left--;
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        stall_left       = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!steady) stall_left = idle_length();
      end
    end
  end

  initial begin : monitor
    olist_pkg::res_t want;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected response: status %0d value %0d position %0d last %0b",
                 status_o, result_value_o, position_o, last_o);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            mismatches++;
          end
          if (result_value_o !== want.value) begin
            $error("result_value: expected %0d, got %0d", want.value, result_value_o);
            mismatches++;
          end
          if (position_o !== want.pos) begin
            $error("position: expected %0d, got %0d", want.pos, position_o);
            mismatches++;
          end
          if (last_o !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last_o);
            mismatches++;
          end
        end
      end
    end
  end

  // ends the run if neither side moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
hdl/olist_pkg.sv
hdl/olist_front.sv
hdl/olist_queue.sv
hdl/olist_back.sv
hdl/ordered_list_engine.sv
sim/ordered_list_engine_test.sv
